// ===== rtl/core/p2h_pkg.sv =====
// Shared constants and types for the pixel to hex cell block.
`default_nettype none
package p2h_pkg;
    localparam int PIXEL_BITS    = 16;
    localparam int HALF_BITS     = 10;
    localparam int QUARTER_BITS  = 9;
    localparam int DIV_BITS      = 11;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 10;
    localparam int COL_BITS      = 16;
    localparam int ROW_BITS      = 15;
    localparam int CUBE_BITS     = 17;
    localparam int DIFF_BITS     = 13;
    localparam int SQ_BITS       = 2 * DIFF_BITS;
    localparam int SUM_BITS      = SQ_BITS + 1;
    localparam int NUM_CAND      = 3;

    localparam logic [HALF_BITS-1:0]    HALF_RESET    = HALF_BITS'(8);
    localparam logic [QUARTER_BITS-1:0] QUARTER_RESET = QUARTER_BITS'(4);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HALF_WIDTH     = 1'b0,
        CFG_QUARTER_HEIGHT = 1'b1
    } t_cfg_reg;
endpackage
`default_nettype wire

// ===== rtl/core/p2h_in_if.sv =====
// Input channel: one pixel position per item.
`default_nettype none
interface p2h_in_if
    import p2h_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/p2h_out_if.sv =====
// Output channel: one hex cell in offset and cube coordinates per item.
`default_nettype none
interface p2h_out_if
    import p2h_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [COL_BITS-1:0]         offset_column;
    logic [ROW_BITS-1:0]         offset_row;
    logic signed [CUBE_BITS-1:0] cube_x;
    logic signed [CUBE_BITS-1:0] cube_y;
    logic [ROW_BITS-1:0]         cube_z;

    modport source (output valid, output offset_column, output offset_row, output cube_x,
                    output cube_y, output cube_z, input ready);
    modport sink   (input valid, input offset_column, input offset_row, input cube_x,
                    input cube_y, input cube_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/p2h_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module p2h_div
    import p2h_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_adv,
    input  wire logic [PIXEL_BITS-1:0] i_num,
    input  wire logic [DIV_BITS-1:0]   i_den,
    output logic [PIXEL_BITS-1:0]      o_quo,
    output logic [DIV_BITS-1:0]        o_rem
);
    logic [DIV_BITS-1:0]   r_rem [PIXEL_BITS];
    logic [PIXEL_BITS-1:0] r_num [PIXEL_BITS];
    logic [PIXEL_BITS-1:0] r_quo [PIXEL_BITS];
    logic [DIV_BITS-1:0]   n_rem [PIXEL_BITS];
    logic [PIXEL_BITS-1:0] n_num [PIXEL_BITS];
    logic [PIXEL_BITS-1:0] n_quo [PIXEL_BITS];

    always_comb begin
        logic [DIV_BITS-1:0]   rem_in;
        logic [PIXEL_BITS-1:0] num_in;
        logic [PIXEL_BITS-1:0] quo_in;
        logic [DIV_BITS:0]     trial;
        logic                  ge;
        for (int k = 0; k < PIXEL_BITS; k++) begin
            if (k == 0) begin
                rem_in = '0;
                num_in = i_num;
                quo_in = '0;
            end else begin
                rem_in = r_rem[k-1];
                num_in = r_num[k-1];
                quo_in = r_quo[k-1];
            end
            trial    = {rem_in, num_in[PIXEL_BITS-1]};
            ge       = (trial >= {1'b0, i_den});
            n_rem[k] = ge ? DIV_BITS'(trial - {1'b0, i_den}) : DIV_BITS'(trial);
            n_num[k] = {num_in[PIXEL_BITS-2:0], 1'b0};
            n_quo[k] = {quo_in[PIXEL_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < PIXEL_BITS; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[PIXEL_BITS-1];
    assign o_rem = r_rem[PIXEL_BITS-1];
endmodule
`default_nettype wire

// ===== rtl/core/pixel_to_hex_cell.sv =====
// Top level: maps a pixel position to its hex cell on an odd-row-shifted grid.
//
// Usage:
//   i_in carries pixel_x and pixel_y; o_out carries the chosen cell as offset
//   column and row plus cube x, y, z. One result per item, in order.
//   Tile size is set through the write port: index 0 half width, index 1
//   quarter height (zero acts as one). Write only while the block is empty.
//   From acceptance to o_out.valid an item passes 16 divider stages
//   (one quotient bit each, both divisions in parallel), then offsets,
//   squares, distance compare and the output register.
//   Throughput is one item per cycle unless o_out stalls. The whole
//   pipeline advances when the output register is empty or being taken,
//   so a stall on o_out freezes every stage and i_in.ready drops in the
//   same cycle; nothing is lost. Synchronous active-low reset clears all
//   valid bits and sets the tile size to half width 8, quarter height 4.
`default_nettype none
module pixel_to_hex_cell
    import p2h_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    p2h_in_if.sink                        i_in,
    p2h_out_if.source                     o_out
);
    logic [HALF_BITS-1:0]    r_half;
    logic [QUARTER_BITS-1:0] r_quarter;
    logic [HALF_BITS-1:0]    half_eff;
    logic [QUARTER_BITS-1:0] quarter_eff;
    logic [DIV_BITS-1:0]     den_x;
    logic [DIV_BITS-1:0]     den_y;
    logic                    adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= HALF_RESET;
            r_quarter <= QUARTER_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_HALF_WIDTH:     r_half    <= i_cfg_data;
                CFG_QUARTER_HEIGHT: r_quarter <= i_cfg_data[QUARTER_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign half_eff    = (r_half == '0) ? HALF_BITS'(1) : r_half;
    assign quarter_eff = (r_quarter == '0) ? QUARTER_BITS'(1) : r_quarter;
    assign den_x       = {half_eff, 1'b0};
    assign den_y       = DIV_BITS'({quarter_eff, 1'b0}) + DIV_BITS'(quarter_eff);

    logic r_out_valid;
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = adv;

    // divider stages
    logic [PIXEL_BITS-1:0] gcol, grow;
    logic [DIV_BITS-1:0]   rx, ry;
    logic [PIXEL_BITS-1:0] r_vld;

    p2h_div u_div_x (.i_clk, .i_adv(adv), .i_num(i_in.pixel_x), .i_den(den_x),
                     .o_quo(gcol), .o_rem(rx));
    p2h_div u_div_y (.i_clk, .i_adv(adv), .i_num(i_in.pixel_y), .i_den(den_y),
                     .o_quo(grow), .o_rem(ry));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIXEL_BITS-2:0], i_in.valid};
        end
    end

    // offsets from each candidate centre
    logic                        r_a_valid;
    logic signed [DIFF_BITS-1:0] r_a_dx [NUM_CAND];
    logic signed [DIFF_BITS-1:0] r_a_dy [NUM_CAND];
    logic [PIXEL_BITS-1:0]       r_a_col, r_a_row;
    logic signed [DIFF_BITS-1:0] n_a_dx [NUM_CAND];
    logic signed [DIFF_BITS-1:0] n_a_dy [NUM_CAND];
    logic [DIV_BITS-1:0]         r_a_rx;

    always_comb begin
        logic signed [DIFF_BITS-1:0] h1, h2, q3, sx, sy;
        h1 = DIFF_BITS'(half_eff);
        h2 = DIFF_BITS'(den_x);
        q3 = DIFF_BITS'(den_y);
        sx = DIFF_BITS'(rx);
        sy = DIFF_BITS'(ry);
        if (grow[0]) begin
            n_a_dx[0] = h1 - sx;  n_a_dy[0] = -sy;
            n_a_dx[1] = -sx;      n_a_dy[1] = q3 - sy;
            n_a_dx[2] = h2 - sx;  n_a_dy[2] = q3 - sy;
        end else begin
            n_a_dx[0] = -sx;      n_a_dy[0] = -sy;
            n_a_dx[1] = h2 - sx;  n_a_dy[1] = -sy;
            n_a_dx[2] = h1 - sx;  n_a_dy[2] = q3 - sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= r_vld[PIXEL_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_dx  <= n_a_dx;
            r_a_dy  <= n_a_dy;
            r_a_col <= gcol;
            r_a_row <= grow;
            r_a_rx  <= rx;
        end
    end

    // squares
    logic                  r_b_valid;
    logic [SQ_BITS-1:0]    r_b_sqx [NUM_CAND];
    logic [SQ_BITS-1:0]    r_b_sqy [NUM_CAND];
    logic [PIXEL_BITS-1:0] r_b_col, r_b_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SQ_BITS-1:0] px, py;
        if (adv) begin
            for (int k = 0; k < NUM_CAND; k++) begin
                px = r_a_dx[k] * r_a_dx[k];
                py = r_a_dy[k] * r_a_dy[k];
                r_b_sqx[k] <= unsigned'(px);
                r_b_sqy[k] <= unsigned'(py);
            end
            r_b_col <= r_a_col;
            r_b_row <= r_a_row;
        end
    end

    // nearest candidate
    logic                  r_c_valid;
    logic [COL_BITS-1:0]   r_c_col;
    logic [ROW_BITS-1:0]   r_c_row;
    logic [SUM_BITS-1:0]   d [NUM_CAND];
    logic [COL_BITS-1:0]   n_c_col;
    logic [ROW_BITS-1:0]   n_c_row;

    always_comb begin
        logic col_inc, row_inc;
        for (int k = 0; k < NUM_CAND; k++) begin
            d[k] = SUM_BITS'(r_b_sqx[k]) + SUM_BITS'(r_b_sqy[k]);
        end
        if (d[0] < d[1] && d[0] < d[2]) begin
            col_inc = 1'b0;
            row_inc = 1'b0;
        end else if (d[1] < d[2]) begin
            col_inc = !r_b_row[0];
            row_inc = r_b_row[0];
        end else begin
            col_inc = r_b_row[0];
            row_inc = 1'b1;
        end
        n_c_col = COL_BITS'(r_b_col) + COL_BITS'(col_inc);
        n_c_row = ROW_BITS'(r_b_row) + ROW_BITS'(row_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_col <= n_c_col;
            r_c_row <= n_c_row;
        end
    end

    // output register with cube coordinates
    logic [COL_BITS-1:0]         r_o_col;
    logic [ROW_BITS-1:0]         r_o_row;
    logic signed [CUBE_BITS-1:0] r_o_cx, r_o_cy;
    logic signed [CUBE_BITS-1:0] n_o_cx;

    assign n_o_cx = signed'(CUBE_BITS'(r_c_col)) - signed'(CUBE_BITS'(r_c_row[ROW_BITS-1:1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_col <= r_c_col;
            r_o_row <= r_c_row;
            r_o_cx  <= n_o_cx;
            r_o_cy  <= -n_o_cx - signed'(CUBE_BITS'(r_c_row));
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.offset_column = r_o_col;
    assign o_out.offset_row    = r_o_row;
    assign o_out.cube_x        = r_o_cx;
    assign o_out.cube_y        = r_o_cy;
    assign o_out.cube_z        = r_o_row;

    a_cube_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> CUBE_BITS'(r_o_cx + r_o_cy + signed'(CUBE_BITS'(r_o_row))) == '0)
        else $error("cube coordinates do not sum to zero");

    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> r_a_rx < den_x)
        else $error("x remainder not below tile width");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_c_valid) && $stable(r_b_valid) && $stable(r_a_valid))
        else $error("pipeline moved during a stall");
endmodule
`default_nettype wire
